### hdl/s2d_pkg.sv
// shared constants and types for the signed integer to decimal text block
package s2d_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW     = DigitW * NumDigits;
  localparam int unsigned CountW   = $clog2(ValueW);
  localparam int unsigned LeftW    = $clog2(NumDigits + 1);

  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;

  typedef struct packed {
    logic            done;
    logic            neg;
    logic [BcdW-1:0] bcd;
  } bcd_word_t;

endpackage

### hdl/s2d_if.sv
// handshake channels for the input value and the output characters
interface s2d_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface s2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

### hdl/s2d_dabble.sv
// bit-serial binary to bcd converter, shift and add three, one bit per cycle
module s2d_dabble (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       neg_i,
  input  logic [s2d_pkg::ValueW-1:0] mag_i,
  output logic                       busy_o,
  output s2d_pkg::bcd_word_t         res_o
);

  logic [s2d_pkg::ValueW-1:0] bin_q, bin_d;
  logic [s2d_pkg::BcdW-1:0]   bcd_q, bcd_d, adj;
  logic [s2d_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       neg_q, neg_d;

  always_comb begin
    for (int i = 0; i < s2d_pkg::NumDigits; i++) begin
      if (bcd_q[i*s2d_pkg::DigitW +: s2d_pkg::DigitW] >= 4'd5) begin
        adj[i*s2d_pkg::DigitW +: s2d_pkg::DigitW] =
          bcd_q[i*s2d_pkg::DigitW +: s2d_pkg::DigitW] + 4'd3;
      end else begin
        adj[i*s2d_pkg::DigitW +: s2d_pkg::DigitW] =
          bcd_q[i*s2d_pkg::DigitW +: s2d_pkg::DigitW];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = '1;
      busy_d = 1'b1;
      neg_d  = neg_i;
    end else if (busy_q) begin
      bcd_d = {adj[s2d_pkg::BcdW-2:0], bin_q[s2d_pkg::ValueW-1]};
      bin_d = {bin_q[s2d_pkg::ValueW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign res_o.done = busy_q && (cnt_q == '0);
  assign res_o.neg  = neg_q;
  assign res_o.bcd  = {adj[s2d_pkg::BcdW-2:0], bin_q[s2d_pkg::ValueW-1]};

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("start while converting");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |=> !busy_q) else $error("converter still busy after done");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && (cnt_q == '1)) else $error("conversion did not start");

endmodule

### hdl/s2d_emit.sv
// digit shifter that sends a minus sign for negative values, drops leading zeros and sends one character per word
module s2d_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  s2d_pkg::bcd_word_t res_i,
  output logic               busy_o,
  s2d_out_if.source          out_o
);

  logic [s2d_pkg::BcdW-1:0]   dig_q, dig_d;
  logic [s2d_pkg::LeftW-1:0]  left_q, left_d;
  logic                       neg_q, neg_d;
  logic                       skip_q, skip_d;
  logic                       valid_q, valid_d;
  logic [7:0]                 char_q, char_d;
  logic                       last_q, last_d;
  logic [s2d_pkg::DigitW-1:0] top;
  logic                       adv;

  assign top = dig_q[s2d_pkg::BcdW-1 -: s2d_pkg::DigitW];
  assign adv = !valid_q || out_o.ready;

  always_comb begin
    dig_d   = dig_q;
    left_d  = left_q;
    neg_d   = neg_q;
    skip_d  = skip_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (res_i.done) begin
      dig_d   = res_i.bcd;
      left_d  = s2d_pkg::LeftW'(s2d_pkg::NumDigits);
      neg_d   = res_i.neg;
      skip_d  = 1'b1;
      valid_d = 1'b0;
    end else if (adv) begin
      valid_d = 1'b0;
      if (neg_q) begin
        valid_d = 1'b1;
        char_d  = s2d_pkg::CharMinus;
        last_d  = 1'b0;
        neg_d   = 1'b0;
      end else if (left_q != '0) begin
        dig_d  = {dig_q[s2d_pkg::BcdW-s2d_pkg::DigitW-1:0], {s2d_pkg::DigitW{1'b0}}};
        left_d = left_q - 1'b1;
        if (!(skip_q && (top == '0) && (left_q != s2d_pkg::LeftW'(1)))) begin
          valid_d = 1'b1;
          char_d  = s2d_pkg::CharZero + {4'd0, top};
          last_d  = (left_q == s2d_pkg::LeftW'(1));
          skip_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      neg_q   <= 1'b0;
      skip_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      neg_q   <= neg_d;
      skip_q  <= skip_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o          = valid_q || neg_q || (left_q != '0);
  assign out_o.valid     = valid_q;
  assign out_o.character = char_q;
  assign out_o.last_char = last_q;

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.done |-> !busy_o) else $error("digits loaded while emitting");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (char_q == s2d_pkg::CharMinus) ||
                ((char_q >= s2d_pkg::CharZero) && (char_q <= s2d_pkg::CharNine)))
    else $error("character out of range");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (char_q == s2d_pkg::CharMinus)) |-> !last_q)
    else $error("minus sign flagged as last");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q && out_o.ready) |=> !busy_o)
    else $error("characters left after last");

endmodule

### hdl/signed_int_to_decimal_ascii.sv
// signed 32-bit integer to decimal ascii text, one character per output word
//
//   channel  dir  payload                      words per value
//   in_i     in   value (32b, signed)          1
//   out_o    out  character (8b), last_char    1 to 11
//
// one value at a time: accept, then the shift-and-add-3 converter takes in the magnitude
// (one input bit per cycle), then a minus sign goes out when negative, then the ten digit
// positions each drop a leading zero or send a digit, and a last step hands off the last
// word
// the output register holds a word while out_o.ready is low; work then pauses
// reset clears all control state; in_i.ready is low until the last word leaves
module signed_int_to_decimal_ascii (
  input  logic      clk_i,
  input  logic      rst_ni,
  s2d_in_if.sink    in_i,
  s2d_out_if.source out_o
);

  logic                       start;
  logic                       neg;
  logic [s2d_pkg::ValueW-1:0] mag;
  logic                       dab_busy;
  logic                       emit_busy;
  s2d_pkg::bcd_word_t         res;

  assign in_i.ready = !dab_busy && !emit_busy;
  assign start      = in_i.valid && in_i.ready;
  assign neg        = in_i.value[s2d_pkg::ValueW-1];
  assign mag        = neg ? ('0 - in_i.value) : in_i.value;

  s2d_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .neg_i   (neg),
    .mag_i   (mag),
    .busy_o  (dab_busy),
    .res_o   (res)
  );

  s2d_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .busy_o (emit_busy),
    .out_o  (out_o)
  );

endmodule
